// File: hdl/dcf_pkg.sv
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int MAX_PAYLOAD    = 128;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam int PAGE_ROWS_LOG2 = 3;

    // header bytes plus checksum
    localparam int MAX_RESULTS = 9;
    localparam int IDX_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic {
        FUNC_HEADER = 1'b0,
        FUNC_DATA   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_GEOMETRY = 2'd2,
        ST_ALIGN    = 2'd3
    } t_status;

    typedef struct packed {
        t_func      func;
        logic [7:0] command;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] block_width;
        logic [7:0] block_height;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } t_item;

    // bytes one item puts on the output, lowest index first
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [IDX_W-1:0]            count;
        logic                        has_end;
        t_status                     status;
    } t_frame;

endpackage

// File: hdl/dcf_core.sv
`timescale 1ns / 1ps

module dcf_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dcf_pkg::t_item i_item,
    input  logic           i_take,
    output dcf_pkg::t_frame o_frame
);
    import dcf_pkg::*;

    logic       r_open, n_open;
    logic [7:0] r_left, n_left;
    logic [7:0] r_sum,  n_sum;
    logic       r_drop, n_drop;

    t_status    hdr_status;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic [7:0] left_dec;
    logic [8:0] x_end;
    logic [8:0] y_end;

    assign x_end    = {1'b0, i_item.pos_x} + {1'b0, i_item.block_width};
    assign y_end    = {1'b0, i_item.pos_y} + {1'b0, i_item.block_height};
    assign hdr_sum  = i_item.command + i_item.pos_x + i_item.pos_y + i_item.block_width
                    + i_item.block_height + i_item.payload_length;
    assign data_sum = r_sum + i_item.data_byte;
    assign left_dec = r_left - 8'd1;

    // length first, then bounds and page alignment for a non-empty block
    always_comb begin
        priority if (i_item.payload_length > 8'(MAX_PAYLOAD)) begin
            hdr_status = ST_TOO_LONG;
        end else if (i_item.block_width == 8'd0 || i_item.block_height == 8'd0) begin
            hdr_status = ST_OK;
        end else if (i_item.pos_x >= 8'(DISPLAY_WIDTH) || i_item.pos_y >= 8'(DISPLAY_HEIGHT)
                     || x_end > 9'(DISPLAY_WIDTH) || y_end > 9'(DISPLAY_HEIGHT)) begin
            hdr_status = ST_GEOMETRY;
        end else if (i_item.block_height[PAGE_ROWS_LOG2-1:0] != '0
                     || i_item.pos_y[PAGE_ROWS_LOG2-1:0] != '0) begin
            hdr_status = ST_ALIGN;
        end else begin
            hdr_status = ST_OK;
        end
    end

    always_comb begin
        o_frame = '0;
        n_open  = r_open;
        n_left  = r_left;
        n_sum   = r_sum;
        n_drop  = r_drop;
        unique case (i_item.func)
            FUNC_HEADER: begin
                n_left = i_item.payload_length;
                if (hdr_status != ST_OK) begin
                    o_frame.count   = IDX_W'(1);
                    o_frame.has_end = 1'b1;
                    o_frame.status  = hdr_status;
                    n_open = 1'b0;
                    n_sum  = 8'd0;
                    n_drop = (i_item.payload_length != 8'd0);
                end else begin
                    o_frame.bytes[0] = SYNC_A;
                    o_frame.bytes[1] = SYNC_B;
                    o_frame.bytes[2] = i_item.command;
                    o_frame.bytes[3] = i_item.pos_x;
                    o_frame.bytes[4] = i_item.pos_y;
                    o_frame.bytes[5] = i_item.block_width;
                    o_frame.bytes[6] = i_item.block_height;
                    o_frame.bytes[7] = i_item.payload_length;
                    o_frame.bytes[8] = hdr_sum;
                    n_drop = 1'b0;
                    if (i_item.payload_length == 8'd0) begin
                        o_frame.count   = IDX_W'(MAX_RESULTS);
                        o_frame.has_end = 1'b1;
                        n_open = 1'b0;
                        n_sum  = 8'd0;
                    end else begin
                        o_frame.count = IDX_W'(MAX_RESULTS - 1);
                        n_open = 1'b1;
                        n_sum  = hdr_sum;
                    end
                end
            end
            FUNC_DATA: begin
                if (r_open) begin
                    o_frame.bytes[0] = i_item.data_byte;
                    o_frame.bytes[1] = data_sum;
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        o_frame.count   = IDX_W'(2);
                        o_frame.has_end = 1'b1;
                        n_open = 1'b0;
                        n_sum  = 8'd0;
                    end else begin
                        o_frame.count = IDX_W'(1);
                        n_sum = data_sum;
                    end
                end else if (r_drop) begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_drop = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 8'd0;
            r_sum  <= 8'd0;
            r_drop <= 1'b0;
        end else if (i_take) begin
            r_open <= n_open;
            r_left <= n_left;
            r_sum  <= n_sum;
            r_drop <= n_drop;
        end
    end

endmodule

// File: hdl/dcf_emitter.sv
`timescale 1ns / 1ps

module dcf_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dcf_pkg::t_frame  i_frame,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_end,
    output dcf_pkg::t_status o_status,
    output logic             o_free
);
    import dcf_pkg::*;

    logic                        r_valid, n_valid;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [IDX_W-1:0]            r_count;
    logic                        r_end;
    t_status                     r_status;
    logic                        last;

    assign last     = (r_idx == r_count - IDX_W'(1));
    assign o_free   = !r_valid || (i_ready && last);
    assign o_valid  = r_valid;
    assign o_byte   = r_bytes[r_idx];
    assign o_end    = r_end && last;
    assign o_status = r_status;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_frame.bytes;
            r_count  <= i_frame.count;
            r_end    <= i_frame.has_end;
            r_status <= i_frame.status;
        end
    end

endmodule

// File: hdl/display_command_framer.sv
`timescale 1ns / 1ps
// channel  | dir | tdata                                      | tuser     | tlast
// s_axis   | in  | command, pos_x, pos_y, block_width,         | func      | -
//          |     | block_height, payload_length, data_byte    |           |
// m_axis   | out | out_byte                                   | status    | frame_end
//
// one input transfer per cycle while each item yields at most one output byte and
// m_axis_tready stays high; the input waits while the output sequencer drains an
// accepted header (8 or 9 bytes) or a closing data byte (byte and checksum)
// an input register and the output sequencer decouple the two sides, so the next
// item is taken while the current result still waits on m_axis_tready
// synchronous active-low reset empties both stages and closes any open frame

module display_command_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, pos_x, pos_y, block_width, block_height, payload_length, data_byte
    input  logic [55:0] s_axis_tdata,
    // func
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte
    output logic [7:0]  m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import dcf_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_item   n_item;
    t_frame  frame;
    t_status out_status;
    logic    free;
    logic    fire;
    logic    load;

    assign n_item.func           = t_func'(s_axis_tuser[0]);
    assign n_item.command        = s_axis_tdata[7:0];
    assign n_item.pos_x          = s_axis_tdata[15:8];
    assign n_item.pos_y          = s_axis_tdata[23:16];
    assign n_item.block_width    = s_axis_tdata[31:24];
    assign n_item.block_height   = s_axis_tdata[39:32];
    assign n_item.payload_length = s_axis_tdata[47:40];
    assign n_item.data_byte      = s_axis_tdata[55:48];

    // items with no result are consumed without touching the sequencer
    assign fire          = r_in_valid && free;
    assign load          = fire && (frame.count != '0);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

    dcf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_take  (fire),
        .o_frame (frame)
    );

    dcf_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_frame  (frame),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_byte   (m_axis_tdata),
        .o_end    (m_axis_tlast),
        .o_status (out_status),
        .o_free   (free)
    );

    assign m_axis_tuser = out_status;

endmodule

// File: hdl/dcf_checker.sv
`timescale 1ns / 1ps

module dcf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import dcf_pkg::*;

    // an error result is a single zero byte that closes the frame
    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("error result without frame end or with nonzero byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
         && $stable(m_axis_tuser)))
        else $error("stalled output transfer changed");

endmodule

bind display_command_framer dcf_checker u_dcf_checker (.*);

// File: tb/sv/frame_scoreboard.sv
`timescale 1ns / 1ps

module frame_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // command, pos_x, pos_y, block_width, block_height, payload_length, data_byte
    input  logic [55:0] i_s_tdata,
    // func
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // out_byte
    input  logic [7:0]  i_m_tdata,
    // status
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import dcf_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        t_status    status;
    } t_link_byte;

    t_link_byte expected_bytes[$];
    t_link_byte want;

    // own copy of the framer state
    logic       open_frame;
    logic [7:0] bytes_to_go;
    logic [7:0] frame_sum;
    logic       dropping;

    int fail_total    = 0;
    int checked_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("[%0t ns] %s: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
        fail_total++;
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic e, input t_status s);
        t_link_byte lb;
        lb.out_byte  = b;
        lb.frame_end = e;
        lb.status    = s;
        expected_bytes.insert(expected_bytes.size(), lb);
    endfunction

    // length first, geometry and page alignment only for a non-empty block
    function automatic t_status header_verdict(input t_item it);
        int x;
        int y;
        int w;
        int h;
        x = it.pos_x;
        y = it.pos_y;
        w = it.block_width;
        h = it.block_height;
        if (int'(it.payload_length) > MAX_PAYLOAD)
            return ST_TOO_LONG;
        if (w == 0 || h == 0)
            return ST_OK;
        if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT ||
            x + w > DISPLAY_WIDTH || y + h > DISPLAY_HEIGHT)
            return ST_GEOMETRY;
        if (it.block_height[PAGE_ROWS_LOG2-1:0] != '0 || it.pos_y[PAGE_ROWS_LOG2-1:0] != '0)
            return ST_ALIGN;
        return ST_OK;
    endfunction

    task automatic predict_frame_bytes(input t_func fn, input logic [55:0] payload);
        t_item   it;
        t_status verdict;
        it.func           = fn;
        it.command        = payload[7:0];
        it.pos_x          = payload[15:8];
        it.pos_y          = payload[23:16];
        it.block_width    = payload[31:24];
        it.block_height   = payload[39:32];
        it.payload_length = payload[47:40];
        it.data_byte      = payload[55:48];
        if (it.func == FUNC_HEADER) begin
            verdict = header_verdict(it);
            if (verdict != ST_OK) begin
                // rejected: single error byte, then drop this frame's payload
                open_frame  = 1'b0;
                frame_sum   = 8'h00;
                bytes_to_go = it.payload_length;
                dropping    = (it.payload_length != 8'h00);
                queue_byte(8'h00, 1'b1, verdict);
            end else begin
                dropping = 1'b0;
                queue_byte(SYNC_A, 1'b0, ST_OK);
                queue_byte(SYNC_B, 1'b0, ST_OK);
                queue_byte(it.command, 1'b0, ST_OK);
                queue_byte(it.pos_x, 1'b0, ST_OK);
                queue_byte(it.pos_y, 1'b0, ST_OK);
                queue_byte(it.block_width, 1'b0, ST_OK);
                queue_byte(it.block_height, 1'b0, ST_OK);
                queue_byte(it.payload_length, 1'b0, ST_OK);
                frame_sum = it.command + it.pos_x + it.pos_y + it.block_width
                          + it.block_height + it.payload_length;
                bytes_to_go = it.payload_length;
                if (it.payload_length == 8'h00) begin
                    queue_byte(frame_sum, 1'b1, ST_OK);
                    open_frame = 1'b0;
                    frame_sum  = 8'h00;
                end else begin
                    open_frame = 1'b1;
                end
            end
        end else if (open_frame) begin
            queue_byte(it.data_byte, 1'b0, ST_OK);
            frame_sum   = frame_sum + it.data_byte;
            bytes_to_go = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'h00) begin
                queue_byte(frame_sum, 1'b1, ST_OK);
                open_frame = 1'b0;
                frame_sum  = 8'h00;
            end
        end else if (dropping) begin
            bytes_to_go = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'h00)
                dropping = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_frame  = 1'b0;
            bytes_to_go = 8'h00;
            frame_sum   = 8'h00;
            dropping    = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_frame_bytes(t_func'(i_s_tuser[0]), i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("output transfer with nothing expected", i_m_tdata, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    checked_total++;
                    if (i_m_tdata !== want.out_byte)
                        report_mismatch("out_byte", i_m_tdata, want.out_byte);
                    if (i_m_tlast !== want.frame_end)
                        report_mismatch("frame_end", i_m_tlast, want.frame_end);
                    if (i_m_tuser !== want.status)
                        report_mismatch("status", i_m_tuser, want.status);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_bytes.size();
        o_checked    <= checked_total;
    end

endmodule

// File: tb/sv/display_command_framer_tb.sv
`timescale 1ns / 1ps

module display_command_framer_tb;

    import dcf_pkg::*;

    localparam int FRAMED_TARGET = 160;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int PAGE_ROWS     = 1 << PAGE_ROWS_LOG2;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_COMB,
        SINK_CHOKE
    } t_sink_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int checked;

    int         cycle_count  = 0;
    int         burst_left   = 0;
    int         header_count = 0;
    int         data_count   = 0;
    t_sink_mode sink_mode    = SINK_OPEN;
    logic [6:0] sink_cycle   = '0;

    display_command_framer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    frame_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: changes its stall style whenever the 7-bit sink_cycle counter wraps
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 7'd1;
        if (sink_cycle == '0)
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            SINK_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            SINK_COMB: begin
                m_axis_tready <= (sink_cycle[2:0] != 3'd0) && (sink_cycle[2:0] != 3'd5);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    task automatic send_item(input t_func fn, input logic [7:0] cmd, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] w, input logic [7:0] h,
                             input logic [7:0] len, input logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, len, h, w, y, x, cmd};
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (fn == FUNC_HEADER)
            header_count++;
        else
            data_count++;
    endtask

    // unused fields of each kind carry random values
    task automatic send_header(input logic [7:0] cmd, input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] w, input logic [7:0] h, input logic [7:0] len);
        send_item(FUNC_HEADER, cmd, x, y, w, h, len, 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] d);
        send_item(FUNC_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), d);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int framed_items;
        int roll;
        int rows;
        int cols;
        int n;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] len;
        bit   paused;

        framed_items = 0;
        paused       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray data with nothing open
        send_data(8'hC3);
        // zero length over the whole screen, extreme field values
        send_header(8'hFF, 8'd0, 8'd0, 8'd128, 8'd64, 8'd0);
        // empty block skips geometry, edge data values
        send_header(8'h00, 8'hFF, 8'hFF, 8'd0, 8'hFF, 8'd3);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h5A);
        // too long with bad geometry too, then a header cuts the dropping short
        send_header(8'h11, 8'd200, 8'd200, 8'd90, 8'd9, 8'd129);
        send_data(8'h01);
        send_data(8'h02);
        // x past the right edge, two bytes dropped, then one stray
        send_header(8'h22, 8'd128, 8'd0, 8'd1, 8'd8, 8'd2);
        send_data(8'h10);
        send_data(8'h20);
        send_data(8'h30);
        // row start not on a page, zero length drops nothing
        send_header(8'h33, 8'd0, 8'd4, 8'd8, 8'd8, 8'd0);
        send_data(8'h40);
        // height not a whole page
        send_header(8'h44, 8'd0, 8'd0, 8'd1, 8'd4, 8'd1);
        send_data(8'h50);
        // longest allowed length, abandoned by a new header
        send_header(8'h55, 8'd0, 8'd0, 8'd16, 8'd8, 8'd128);
        send_data(8'h60);
        send_data(8'h70);
        send_header(8'h66, 8'd127, 8'd56, 8'd1, 8'd8, 8'd1);
        send_data(8'h80);
        // bottom edge overrun
        send_header(8'h77, 8'd0, 8'd56, 8'd8, 8'd16, 8'd0);

        while (framed_items < FRAMED_TARGET) begin
            if (!paused && framed_items >= FRAMED_TARGET / 2) begin
                // sender holds off until every expected byte has come out
                wait_until_drained();
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                paused = 1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if ($urandom_range(0, 9) == 0) begin
                    x = 8'($urandom);
                    y = 8'($urandom);
                    if ($urandom_range(0, 1) == 0) begin
                        w = 8'd0;
                        h = 8'($urandom);
                    end else begin
                        w = 8'($urandom);
                        h = 8'd0;
                    end
                end else begin
                    rows = PAGE_ROWS * $urandom_range(1, DISPLAY_HEIGHT / PAGE_ROWS);
                    y    = 8'(PAGE_ROWS * $urandom_range(0, (DISPLAY_HEIGHT - rows) / PAGE_ROWS));
                    h    = 8'(rows);
                    cols = $urandom_range(1, DISPLAY_WIDTH);
                    w    = 8'(cols);
                    x    = 8'($urandom_range(0, DISPLAY_WIDTH - cols));
                end
                roll = $urandom_range(0, 19);
                if (roll < 2)
                    len = 8'd0;
                else if (roll < 17)
                    len = 8'($urandom_range(1, 8));
                else if (roll < 19)
                    len = 8'($urandom_range(9, 40));
                else
                    len = 8'($urandom_range(41, MAX_PAYLOAD));
                n = len;
                if (len != 0 && $urandom_range(0, 9) == 0)
                    n = $urandom_range(0, len - 1);
                send_header(8'($urandom), x, y, w, h, len);
                repeat (n) send_data(8'($urandom));
                framed_items += 1 + n;
            end else if (roll < 88) begin
                // unconstrained header, often rejected, with a few bytes after it
                len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 10)) : 8'($urandom);
                send_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), len);
                repeat ($urandom_range(0, 4)) send_data(8'($urandom));
                framed_items++;
            end else begin
                repeat ($urandom_range(1, 3)) send_data(8'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d header items and %0d data items under random gaps and stalls",
                 header_count, data_count);
        $display("compared %0d output bytes, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
